// ===== design/sadf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sadf_pkg;

  localparam int MAX_RECORDS_DEF = 256;
  localparam int RECORD_BYTES    = 16;
  localparam int HEAP_MAX        = 65536;

  localparam int SIZE_W = 17;
  localparam int ADDR_W = 16;
  localparam int TOP_W  = 17;
  localparam int RSV_W  = 7;
  localparam int CFG_W  = 17;
  localparam int CFG_AW = 1;

  localparam logic [CFG_AW-1:0] REG_HEAP_SIZE     = 1'd0;
  localparam logic [CFG_AW-1:0] REG_RESERVE_SLOTS = 1'd1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_OOM   = 3'd1,
    ST_DEFER = 3'd2,
    ST_EMPTY = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] offset;
    logic [TOP_W-1:0]  top_after;
  } out_t;

  typedef struct packed {
    logic vld;
    out_t data;
  } res_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] len;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage
`default_nettype wire

// ===== design/sadf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sadf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/sadf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sadf_ctrl import sadf_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire in_t              in_data,
  input  wire logic             out_free,
  input  wire logic [CFG_W-1:0] heap_size,
  input  wire logic [RSV_W-1:0] reserve_slots,
  output logic                  in_ready,
  output res_t                  res
);

  localparam int IW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int SUM_W = SIZE_W + 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RECORDS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EV   = 3'b100
  } state_e;

  state_e            state_r, state_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic              trim_r, trim_nxt;
  status_e           stat_r, stat_nxt;

  logic              we;
  logic [IW-1:0]     waddr;
  rec_t              wdata;
  rec_t              rec;
  logic [REC_W-1:0]  rdata;

  logic signed [31:0] eh, freeb;
  logic [CW-1:0]      cm1;
  logic               last, hit, pop, accept;

  sadf_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cur_r),
    .rdata (rdata)
  );

  assign rec      = rec_t'(rdata);
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign eh = (heap_size > CFG_W'(HEAP_MAX)) ? 32'(HEAP_MAX) : 32'(heap_size);
  assign last = (CW'(cur_r) + 1'b1) == cnt_r;
  assign hit  = (SUM_W'(rec.addr) + SUM_W'(rec.len)) == SUM_W'(top_r);
  assign pop  = (SUM_W'(in_data.address) + SUM_W'(in_data.size)) == SUM_W'(top_r);

  always_comb begin
    freeb = eh - 32'(top_r) - ((32'(cnt_r) + 32'(reserve_slots)) * 32'(RECORD_BYTES));
    if (freeb < 0) begin
      freeb = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    top_nxt   = top_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    trim_nxt  = trim_r;
    stat_nxt  = stat_r;
    we        = 1'b0;
    waddr     = cur_r;
    wdata     = '0;
    res       = '0;
    cm1       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(in_data.cmd))
            CMD_ALLOC: begin
              res.vld = 1'b1;
              if (32'(in_data.size) > freeb) begin
                res.data.status = ST_OOM;
              end else begin
                res.data.offset = top_r[ADDR_W-1:0];
                top_nxt = top_r + in_data.size;
              end
              res.data.top_after = top_nxt;
            end
            CMD_FREE: begin
              stat_nxt = ST_DONE;
              if (top_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else if (pop) begin
                top_nxt = top_r - in_data.size;
              end else if (cnt_r >= CNT_MAX) begin
                stat_nxt = ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = cnt_r[IW-1:0];
                wdata    = '{vld: 1'b1, addr: in_data.address, len: in_data.size};
                cnt_nxt  = cnt_r + 1'b1;
                stat_nxt = ST_DEFER;
              end
              // walk the records from the newest, or finish at once if none
              if (cnt_nxt == '0) begin
                res.vld            = 1'b1;
                res.data.status    = stat_nxt;
                res.data.top_after = top_nxt;
              end else begin
                cm1       = cnt_nxt - 1'b1;
                cur_nxt   = cm1[IW-1:0];
                trim_nxt  = 1'b0;
                state_nxt = S_RD;
              end
            end
            CMD_CLEAR: begin
              top_nxt            = '0;
              cnt_nxt            = '0;
              res.vld            = 1'b1;
              res.data.top_after = '0;
            end
            default: begin
              res.vld            = 1'b1;
              res.data.top_after = top_r;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        state_nxt = S_RD;
        if (trim_r && !rec.vld) begin
          cnt_nxt = cnt_r - 1'b1;
        end else if (rec.vld && hit) begin
          top_nxt = top_r - rec.len;
          we      = 1'b1;
          waddr   = cur_r;
          wdata   = '{vld: 1'b0, addr: rec.addr, len: rec.len};
          if (last) begin
            cnt_nxt  = cnt_r - 1'b1;
            trim_nxt = 1'b1;
          end else begin
            cm1      = cnt_r - 1'b1;
            trim_nxt = 1'b0;
          end
        end else begin
          trim_nxt = 1'b0;
        end
        if (rec.vld && hit && !last && !(trim_r && !rec.vld)) begin
          cur_nxt = cm1[IW-1:0];
        end else if (cur_r == '0) begin
          state_nxt          = S_IDLE;
          res.vld            = 1'b1;
          res.data.status    = stat_r;
          res.data.top_after = top_nxt;
        end else begin
          cur_nxt = cur_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      top_r   <= '0;
      cnt_r   <= '0;
      trim_r  <= 1'b0;
      stat_r  <= ST_DONE;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      cnt_r   <= cnt_nxt;
      trim_r  <= trim_nxt;
      stat_r  <= stat_nxt;
      cur_r   <= cur_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX) else $error("record count over capacity");
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(top_r) <= 32'(HEAP_MAX)) else $error("top beyond heap");
  a_walk_res: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> !res.vld) else $error("result during read");
  a_walk_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (CW'(cur_r) < cnt_r)) else $error("walk past count");

endmodule
`default_nettype wire

// ===== design/stack_allocator_deferred_free.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bump-pointer stack allocator with a deferred free list. Alloc, clear and
// no-op beats return their result in the cycle after they are accepted. A
// free beat walks the stored records from the newest, with a read state
// and an evaluate state of the record RAM per record visited (single port
// per direction); the walk restarts at the newest record after each pop of
// an older one, so its length depends on the record contents. A free beat
// that leaves no records finishes at once. One beat is in work at a time.
// The result sits in an output register; a new input beat is taken only
// while that register is empty or drained in the same cycle, so a waiting
// result holds the input. No clearing pass after reset.
module stack_allocator_deferred_free import sadf_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  logic [CFG_W-1:0] heap_size_r;
  logic [RSV_W-1:0] reserve_r;
  logic             out_valid_r;
  out_t             out_data_r;
  res_t             res;
  logic             out_free;

  // slot is free when empty or drained this cycle
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  sadf_ctrl #(.MAX_RECORDS(MAX_RECORDS)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .out_free      (out_free),
    .heap_size     (heap_size_r),
    .reserve_slots (reserve_r),
    .in_ready      (in_ready),
    .res           (res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r <= CFG_W'(65536);
      reserve_r   <= RSV_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HEAP_SIZE:     heap_size_r <= cfg_wdata;
        REG_RESERVE_SLOTS: reserve_r   <= cfg_wdata[RSV_W-1:0];
        default: ;
      endcase
    end
  end

  // output beat register: load on result, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_data_r <= res.data;
    end
  end

endmodule
`default_nettype wire
